/* rtl/dspv_pkg.sv */
// Package for the date string parser: field and status codes, result item layout
// and the small calendar helper functions.
// No dependencies; used by date_string_parse_validate_core.
package dspv_pkg;

    localparam int CHAR_W  = 8;
    localparam int ACC_W   = 14;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int DIM_W   = 5;
    localparam int STAT_W  = 3;
    localparam int OUT_W   = 32;

    localparam logic [CHAR_W-1:0] DELIM_RESET = 8'd46;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'd57;
    localparam logic [CHAR_W-1:0] CHAR_END    = 8'd0;

    localparam logic [ACC_W-1:0] ACC_SAT  = 14'd10000;
    localparam logic [ACC_W-1:0] YEAR_MAX = 14'd9999;
    localparam logic [5:0]       DAY_SAT  = 6'd63;
    localparam logic [3:0]       MON_SAT  = 4'd13;
    localparam logic [3:0]       MON_MAX  = 4'd12;

    typedef enum logic [1:0] {
        FIELD_DAY   = 2'd0,
        FIELD_MONTH = 2'd1,
        FIELD_YEAR  = 2'd2
    } t_field;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_FORMAT    = 3'd1,
        ST_BAD_YEAR  = 3'd2,
        ST_BAD_MONTH = 3'd3,
        ST_BAD_DAY   = 3'd4
    } t_status;

    // Result item, last field (status) in the lowest bits.
    typedef struct packed {
        logic                 pad;
        logic [DIM_W-1:0]     days_in_month;
        logic [ACC_W-1:0]     year;
        logic [MONTH_W-1:0]   month;
        logic [DAY_W-1:0]     day;
        logic [STAT_W-1:0]    status;
    } t_result;

    // (10 * r) mod 25 for a residue r below 25.
    function automatic logic [4:0] mul10_mod25(input logic [4:0] r);
        logic [4:0] res;
        case (r)
            5'd0, 5'd5, 5'd10, 5'd15, 5'd20: res = 5'd0;
            5'd1, 5'd6, 5'd11, 5'd16, 5'd21: res = 5'd10;
            5'd2, 5'd7, 5'd12, 5'd17, 5'd22: res = 5'd20;
            5'd3, 5'd8, 5'd13, 5'd18, 5'd23: res = 5'd5;
            5'd4, 5'd9, 5'd14, 5'd19, 5'd24: res = 5'd15;
            default:                         res = 5'd0;
        endcase
        return res;
    endfunction

    // Month length; zero for a month outside 1 to 12.
    function automatic logic [DIM_W-1:0] month_length(input logic [3:0] m, input logic leap);
        logic [DIM_W-1:0] res;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: res = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    res = 5'd30;
            4'd2:                                       res = leap ? 5'd29 : 5'd28;
            default:                                    res = 5'd0;
        endcase
        return res;
    endfunction

endpackage

/* rtl/date_string_parse_validate_core.sv */
// Date string parser and validator: day, month and year fields with the leap-year rule.
// Depends on dspv_pkg for codes, the result layout and the calendar helpers.
//
//  channel   direction  handshake                 payload
//  s         in         i_s_tvalid / o_s_tready   i_s_tdata: character
//  m         out        o_m_tvalid / i_m_tready   o_m_tdata: status, day, month, year, dim
//  cfg       in         i_cfg_valid / o_cfg_ready i_cfg_data: delimiter
//
// One character is taken every cycle while no terminator waits in the input register. Each
// item is held in the input register and is then folded into the parse state; the zero byte
// also loads the result register, which then offers the result. Only a terminator waits on a
// full, stalled result register; other characters pass regardless.
// Reset (synchronous, active low) clears the parse state and sets the delimiter to '.'.
module date_string_parse_validate_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [dspv_pkg::CHAR_W-1:0]   i_s_tdata,   // [7:0] character
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [dspv_pkg::OUT_W-1:0]    o_m_tdata,   // [2:0] status, [7:3] day,
                                                       // [11:8] month, [25:12] year,
                                                       // [30:26] days_in_month, [31] zero
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dspv_pkg::CHAR_W-1:0]   i_cfg_data   // [7:0] delimiter
);
    import dspv_pkg::*;

    logic [CHAR_W-1:0]  r_delim;
    logic               r_in_vld;
    logic [CHAR_W-1:0]  r_char;

    t_field             r_field,  n_field;
    logic [ACC_W-1:0]   r_acc,    n_acc;
    logic [4:0]         r_m25,    n_m25;
    logic [5:0]         r_day,    n_day;
    logic [3:0]         r_mon,    n_mon;
    logic               r_fmt,    n_fmt;
    logic               r_seen,   n_seen;

    logic               r_out_vld;
    t_result            r_out,    n_out;

    logic               is_end;
    logic               is_digit;
    logic               advance;
    logic [3:0]         digit;
    logic [16:0]        acc_x10;
    logic [4:0]         m25_sum;
    logic               fmt_final;
    logic [5:0]         d_val;
    logic [3:0]         m_val;
    logic [ACC_W-1:0]   y_val;
    logic               leap;
    logic [DIM_W-1:0]   dim;
    t_status            status;

    assign o_cfg_ready = 1'b1;

    assign is_end   = (r_char == CHAR_END);
    assign is_digit = (r_char >= CHAR_ZERO) && (r_char <= CHAR_NINE);
    assign digit    = 4'(r_char - CHAR_ZERO);

    // Only a terminator produces a result, so only it waits for the result register.
    assign advance    = r_in_vld && (!is_end || !r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || advance;

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out;

    always_comb begin
        acc_x10 = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0} + 17'(digit);
        // Residue mod 25 runs alongside the accumulator for the century tests.
        m25_sum = 5'(mul10_mod25(r_m25) + 5'(digit));
        if (m25_sum >= 5'd25) begin
            m25_sum = 5'(m25_sum - 5'd25);
        end
    end

    always_comb begin
        fmt_final = r_fmt || ((r_field != FIELD_YEAR) && r_seen);
        d_val     = r_day;
        m_val     = '0;
        y_val     = '0;
        case (r_field)
            FIELD_DAY: begin
                d_val = (r_acc > ACC_W'(DAY_SAT)) ? DAY_SAT : 6'(r_acc);
            end
            FIELD_MONTH: begin
                m_val = (r_acc > ACC_W'(MON_SAT)) ? MON_SAT : 4'(r_acc);
            end
            FIELD_YEAR: begin
                m_val = r_mon;
                y_val = r_acc;
            end
            default: begin
                m_val = '0;
            end
        endcase

        // Divisible by 4 and not by 100, or divisible by 400 (16 and 25).
        leap = (y_val[1:0] == 2'b00) && ((r_m25 != 5'd0) || (y_val[3:0] == 4'b0000));
        dim  = '0;
        if (fmt_final) begin
            status = ST_FORMAT;
        end else if (y_val > YEAR_MAX) begin
            status = ST_BAD_YEAR;
        end else if ((m_val > MON_MAX) || (m_val == 4'd0)) begin
            status = ST_BAD_MONTH;
        end else begin
            dim    = month_length(m_val, leap);
            status = (d_val > 6'(dim)) ? ST_BAD_DAY : ST_OK;
        end

        n_out        = '0;
        n_out.status = status;
        if (status == ST_OK) begin
            n_out.day   = d_val[DAY_W-1:0];
            n_out.month = m_val;
            n_out.year  = y_val;
        end
        if ((status == ST_OK) || (status == ST_BAD_DAY)) begin
            n_out.days_in_month = dim;
        end
    end

    always_comb begin
        n_field = r_field;
        n_acc   = r_acc;
        n_m25   = r_m25;
        n_day   = r_day;
        n_mon   = r_mon;
        n_fmt   = r_fmt;
        n_seen  = r_seen;
        if (advance) begin
            if (is_end) begin
                n_field = FIELD_DAY;
                n_acc   = '0;
                n_m25   = '0;
                n_day   = '0;
                n_mon   = '0;
                n_fmt   = 1'b0;
                n_seen  = 1'b0;
            end else if (!r_fmt) begin
                if (is_digit) begin
                    n_acc  = (acc_x10 > 17'(ACC_SAT)) ? ACC_SAT : ACC_W'(acc_x10);
                    n_m25  = m25_sum;
                    n_seen = 1'b1;
                end else if ((r_char == r_delim) && (r_field != FIELD_YEAR)) begin
                    if (r_field == FIELD_DAY) begin
                        n_day   = (r_acc > ACC_W'(DAY_SAT)) ? DAY_SAT : 6'(r_acc);
                        n_field = FIELD_MONTH;
                    end else begin
                        n_mon   = (r_acc > ACC_W'(MON_SAT)) ? MON_SAT : 4'(r_acc);
                        n_field = FIELD_YEAR;
                    end
                    n_acc  = '0;
                    n_m25  = '0;
                    n_seen = 1'b0;
                end else begin
                    n_fmt = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim   <= DELIM_RESET;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_field   <= FIELD_DAY;
            r_acc     <= '0;
            r_m25     <= '0;
            r_day     <= '0;
            r_mon     <= '0;
            r_fmt     <= 1'b0;
            r_seen    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_delim <= i_cfg_data;
            end
            if (o_s_tready) begin
                r_in_vld <= i_s_tvalid;
            end
            if (advance && is_end) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            r_field <= n_field;
            r_acc   <= n_acc;
            r_m25   <= n_m25;
            r_day   <= n_day;
            r_mon   <= n_mon;
            r_fmt   <= n_fmt;
            r_seen  <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_char <= i_s_tdata;
        end
        if (advance && is_end) begin
            r_out <= n_out;
        end
    end

endmodule
